// ===== hdl/vmra_pkg.sv =====
package vmra_pkg;

    // Ring geometry (RING_BYTES is a power of two)
    localparam int unsigned RING_BYTES   = 1024;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned MAX_BATCH    = 64;
    localparam int unsigned MAX_WALK     = 128;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned AW      = $clog2(RING_BYTES);
    localparam int unsigned SIZE_W  = 10;
    localparam int unsigned OFF_W   = 10;
    localparam int unsigned STEP_W  = $clog2(RING_BYTES + (1 << SIZE_W) + HEADER_BYTES);
    localparam int unsigned BATCH_W = $clog2(MAX_BATCH + 1);
    localparam int unsigned WALK_W  = $clog2(MAX_WALK + 1);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_COMMIT  = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [SIZE_W-1:0] req_bytes;
    } t_in_item;

    typedef struct packed {
        logic [OFF_W-1:0]  msg_offset;
        logic [SIZE_W-1:0] msg_bytes;
        t_status           status;
        logic              last_of_run;
    } t_out_item;

    // Stored header: padding mark and payload size
    typedef struct packed {
        logic              pad;
        logic [SIZE_W-1:0] bytes;
    } t_hdr;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_COUNT,
        OP_AL_SUM,
        OP_AL_PAD,
        OP_AL_TAKE,
        OP_AL_FULL,
        OP_AL_WPAD,
        OP_AL_WHDR,
        OP_DQ_INIT,
        OP_DQ_READ,
        OP_DQ_EVAL,
        OP_DQ_DONE
    } t_dp_op;

    typedef struct packed {
        logic out_free;
        logic is_full;
        logic padded;
        logic hdr_pad;
        logic pend_valid;
        logic walk_more;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COUNT,
        S_AL_SUM,
        S_AL_PAD,
        S_AL_CHK,
        S_AL_FULL,
        S_AL_WPAD,
        S_AL_WHDR,
        S_DQ_INIT,
        S_DQ_READ,
        S_DQ_EVAL,
        S_DQ_DONE
    } t_state;

    // Ring offset of a position, cut to the reported offset width
    function automatic logic [OFF_W-1:0] to_msg_off(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] masked;
        masked = pos & POS_W'(RING_BYTES - 1);
        return masked[OFF_W-1:0];
    endfunction

endpackage

// ===== hdl/variable_message_ring_allocator_top.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_in  (cmd, req_bytes)
// out      output     o_out_valid / i_out_ready o_out (msg_offset, msg_bytes,
//                                                      status, last_of_run)
//
// Allocate writes a padding header first when the message wraps.
// Dequeue walks the stored headers (one header store read and one evaluate
// step each), up to 128 headers.
// Reset is synchronous and active low; the header store is not cleared.
// A full output register stalls the block until the result is taken.
module variable_message_ring_allocator_top import vmra_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    // Sequence each command
    vmra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in.cmd),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_op       (dp_op)
    );

    // Hold pointers, header store and output slot
    vmra_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_op        (dp_op),
        .i_out_ready (i_out_ready),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== hdl/vmra_ctrl.sv =====
module vmra_ctrl import vmra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_in_cmd,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_op   o_op
);

    t_state r_state;
    t_state n_state;
    logic   eval_stall;

    // A new message cannot displace the pending one until the output slot frees
    assign eval_stall = !i_stat.hdr_pad && i_stat.pend_valid && !i_stat.out_free;

    // Hold state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_ALLOC:   n_state = S_AL_SUM;
                        CMD_DEQUEUE: n_state = S_DQ_INIT;
                        default:     n_state = S_COUNT;
                    endcase
                end
            end
            S_COUNT:   n_state = S_IDLE;
            S_AL_SUM:  n_state = S_AL_PAD;
            S_AL_PAD:  n_state = S_AL_CHK;
            S_AL_CHK: begin
                if (i_stat.is_full) begin
                    n_state = S_AL_FULL;
                end else if (i_stat.padded) begin
                    n_state = S_AL_WPAD;
                end else begin
                    n_state = S_AL_WHDR;
                end
            end
            S_AL_FULL: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_AL_WPAD: n_state = S_AL_WHDR;
            S_AL_WHDR: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DQ_INIT: n_state = S_DQ_READ;
            S_DQ_READ: n_state = i_stat.walk_more ? S_DQ_EVAL : S_DQ_DONE;
            S_DQ_EVAL: begin
                if (!eval_stall) begin
                    n_state = S_DQ_READ;
                end
            end
            S_DQ_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_in_ready = 1'b0;
        o_op       = OP_NOP;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    o_op = OP_LATCH;
                end
            end
            S_COUNT:   o_op = OP_COUNT;
            S_AL_SUM:  o_op = OP_AL_SUM;
            S_AL_PAD:  o_op = OP_AL_PAD;
            S_AL_CHK:  o_op = i_stat.is_full ? OP_NOP : OP_AL_TAKE;
            S_AL_FULL: o_op = i_stat.out_free ? OP_AL_FULL : OP_NOP;
            S_AL_WPAD: o_op = OP_AL_WPAD;
            S_AL_WHDR: o_op = i_stat.out_free ? OP_AL_WHDR : OP_NOP;
            S_DQ_INIT: o_op = OP_DQ_INIT;
            S_DQ_READ: o_op = i_stat.walk_more ? OP_DQ_READ : OP_NOP;
            S_DQ_EVAL: o_op = eval_stall ? OP_NOP : OP_DQ_EVAL;
            S_DQ_DONE: o_op = i_stat.out_free ? OP_DQ_DONE : OP_NOP;
            default:   o_op = OP_NOP;
        endcase
    end

endmodule

// ===== hdl/vmra_dp.sv =====
module vmra_dp import vmra_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_dp_op    i_op,
    input  logic      i_out_ready,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_item o_out
);

    // Ring pointers and counts
    logic [POS_W-1:0]   r_alloc_pos,  n_alloc_pos;
    logic [POS_W-1:0]   r_alloc_cnt,  n_alloc_cnt;
    logic [POS_W-1:0]   r_commit_pos, n_commit_pos;
    logic [POS_W-1:0]   r_commit_cnt, n_commit_cnt;
    logic [POS_W-1:0]   r_take_pos,   n_take_pos;
    logic [POS_W-1:0]   r_take_cnt,   n_take_cnt;
    logic [POS_W-1:0]   r_free_pos,   n_free_pos;
    logic [POS_W-1:0]   r_free_cnt,   n_free_cnt;

    // Latched command
    t_cmd               r_cmd,  n_cmd;
    logic [SIZE_W-1:0]  r_size, n_size;

    // Allocate scratch
    logic [POS_W-1:0]   r_nh,      n_nh;
    logic               r_padded,  n_padded;
    logic [AW-1:0]      r_at,      n_at;
    logic [AW-1:0]      r_pad_off, n_pad_off;

    // Dequeue walk
    logic [POS_W-1:0]   r_cursor, n_cursor;
    logic [POS_W-1:0]   r_remain, n_remain;
    logic [BATCH_W-1:0] r_n,      n_n;
    logic [WALK_W-1:0]  r_steps,  n_steps;
    logic               r_pend_valid, n_pend_valid;
    logic [AW-1:0]      r_pend_off,   n_pend_off;
    logic [SIZE_W-1:0]  r_pend_bytes, n_pend_bytes;

    // Output slot
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out,       n_out;

    // Header store
    t_hdr               r_mem [RING_BYTES];
    t_hdr               r_rd;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_hdr               mem_wdata;

    logic               out_free;
    logic [POS_W-1:0]   sum_nh;
    logic               sum_padded;
    logic [POS_W-1:0]   neg_head;
    logic [POS_W-1:0]   pad_amt;
    logic [AW-1:0]      ev_off;
    logic [STEP_W-1:0]  ev_step;
    logic [POS_W-1:0]   ev_adv;

    assign out_free = !r_out_valid || i_out_ready;

    // Allocate arithmetic
    assign sum_nh     = r_alloc_pos + POS_W'(r_size) + POS_W'(HEADER_BYTES);
    assign sum_padded = ((sum_nh & POS_W'(RING_BYTES - 1)) != '0)
                     && ((r_alloc_pos >> AW) != (sum_nh >> AW));
    assign neg_head   = '0 - r_alloc_pos;
    assign pad_amt    = neg_head & POS_W'(RING_BYTES - 1);

    // Walk step from the header just read
    assign ev_off  = r_cursor[AW-1:0];
    assign ev_step = r_rd.pad ? (STEP_W'(RING_BYTES) - STEP_W'(ev_off))
                              : (STEP_W'(r_rd.bytes) + STEP_W'(HEADER_BYTES));
    assign ev_adv  = (POS_W'(ev_step) >= r_remain) ? r_remain : POS_W'(ev_step);

    // Status to the controller
    assign o_stat.out_free   = out_free;
    assign o_stat.is_full    = (r_nh - r_free_pos) > POS_W'(RING_BYTES);
    assign o_stat.padded     = r_padded;
    assign o_stat.hdr_pad    = r_rd.pad;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.walk_more  = (r_remain != '0) && (r_n < BATCH_W'(MAX_BATCH))
                            && (r_steps < WALK_W'(MAX_WALK));

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Next values per command
    always_comb begin
        n_alloc_pos  = r_alloc_pos;
        n_alloc_cnt  = r_alloc_cnt;
        n_commit_pos = r_commit_pos;
        n_commit_cnt = r_commit_cnt;
        n_take_pos   = r_take_pos;
        n_take_cnt   = r_take_cnt;
        n_free_pos   = r_free_pos;
        n_free_cnt   = r_free_cnt;
        n_cmd        = r_cmd;
        n_size       = r_size;
        n_nh         = r_nh;
        n_padded     = r_padded;
        n_at         = r_at;
        n_pad_off    = r_pad_off;
        n_cursor     = r_cursor;
        n_remain     = r_remain;
        n_n          = r_n;
        n_steps      = r_steps;
        n_pend_valid = r_pend_valid;
        n_pend_off   = r_pend_off;
        n_pend_bytes = r_pend_bytes;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_waddr    = r_at;
        mem_wdata    = '{pad: 1'b0, bytes: r_size};
        case (i_op)
            OP_LATCH: begin
                n_cmd  = i_in.cmd;
                n_size = i_in.req_bytes;
            end
            OP_COUNT: begin
                if (r_cmd == CMD_COMMIT) begin
                    n_commit_cnt = r_commit_cnt + 1'b1;
                    if (n_commit_cnt == r_alloc_cnt) begin
                        n_commit_pos = r_alloc_pos;
                    end
                end else begin
                    n_free_cnt = r_free_cnt + 1'b1;
                    if (n_free_cnt == r_take_cnt) begin
                        n_free_pos = r_take_pos;
                    end
                end
            end
            OP_AL_SUM: begin
                n_nh      = sum_nh;
                n_padded  = sum_padded;
                n_at      = sum_padded ? '0 : r_alloc_pos[AW-1:0];
                n_pad_off = r_alloc_pos[AW-1:0];
            end
            OP_AL_PAD: begin
                if (r_padded) begin
                    n_nh = r_nh + pad_amt;
                end
            end
            OP_AL_TAKE: begin
                n_alloc_pos = r_nh;
                n_alloc_cnt = r_alloc_cnt + 1'b1;
            end
            OP_AL_FULL: begin
                n_out_valid = 1'b1;
                n_out       = '{msg_offset: '0, msg_bytes: '0,
                                status: ST_FULL, last_of_run: 1'b1};
            end
            OP_AL_WPAD: begin
                mem_we    = 1'b1;
                mem_waddr = r_pad_off;
                mem_wdata = '{pad: 1'b1, bytes: r_size};
            end
            OP_AL_WHDR: begin
                mem_we      = 1'b1;
                n_out_valid = 1'b1;
                n_out       = '{msg_offset: to_msg_off(POS_W'(r_at)), msg_bytes: r_size,
                                status: ST_OK, last_of_run: 1'b1};
            end
            OP_DQ_INIT: begin
                n_cursor     = r_take_pos;
                n_remain     = r_commit_pos - r_take_pos;
                n_n          = '0;
                n_steps      = '0;
                n_pend_valid = 1'b0;
            end
            OP_DQ_EVAL: begin
                n_cursor = r_cursor + ev_adv;
                n_remain = r_remain - ev_adv;
                n_steps  = r_steps + 1'b1;
                if (!r_rd.pad) begin
                    n_n = r_n + 1'b1;
                    // Release the previous message; this one becomes pending
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = '{msg_offset: to_msg_off(POS_W'(r_pend_off)),
                                        msg_bytes: r_pend_bytes,
                                        status: ST_OK, last_of_run: 1'b0};
                    end
                    n_pend_valid = 1'b1;
                    n_pend_off   = ev_off;
                    n_pend_bytes = r_rd.bytes;
                end
            end
            OP_DQ_DONE: begin
                n_out_valid = 1'b1;
                if (r_pend_valid) begin
                    n_out = '{msg_offset: to_msg_off(POS_W'(r_pend_off)),
                              msg_bytes: r_pend_bytes,
                              status: ST_OK, last_of_run: 1'b1};
                end else begin
                    n_out = '{msg_offset: '0, msg_bytes: '0,
                              status: ST_EMPTY, last_of_run: 1'b1};
                end
                n_take_pos   = r_cursor;
                n_take_cnt   = r_take_cnt + POS_W'(r_n);
                n_pend_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_pos  <= '0;
            r_alloc_cnt  <= '0;
            r_commit_pos <= '0;
            r_commit_cnt <= '0;
            r_take_pos   <= '0;
            r_take_cnt   <= '0;
            r_free_pos   <= '0;
            r_free_cnt   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_alloc_pos  <= n_alloc_pos;
            r_alloc_cnt  <= n_alloc_cnt;
            r_commit_pos <= n_commit_pos;
            r_commit_cnt <= n_commit_cnt;
            r_take_pos   <= n_take_pos;
            r_take_cnt   <= n_take_cnt;
            r_free_pos   <= n_free_pos;
            r_free_cnt   <= n_free_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_size       <= n_size;
        r_nh         <= n_nh;
        r_padded     <= n_padded;
        r_at         <= n_at;
        r_pad_off    <= n_pad_off;
        r_cursor     <= n_cursor;
        r_remain     <= n_remain;
        r_n          <= n_n;
        r_steps      <= n_steps;
        r_pend_off   <= n_pend_off;
        r_pend_bytes <= n_pend_bytes;
        r_out        <= n_out;
    end

    // Header store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_op == OP_DQ_READ) begin
            r_rd <= r_mem[r_cursor[AW-1:0]];
        end
    end

endmodule
